// File: sv/pss_pkg.sv
package pss_pkg;

  // default store depth
  localparam int PSS_CAPACITY = 16;

  // field widths
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_FWD  = 3'd6;
  localparam logic [OP_W-1:0] OP_READ_BWD  = 3'd7;

  // status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] STAT_RANGE = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic rot_l;
    logic rot_r;
  } pss_cell_ctl_t;

endpackage

// File: sv/pss_cell.sv
module pss_cell
  import pss_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic                    clk,
  input  pss_cell_ctl_t           ctl_i,
  input  logic        [IDX_W-1:0] idx_i,
  input  logic signed [VAL_W-1:0] load_value_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] value_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    below;
  logic                    at;

  assign below = MY_IDX < idx_i;
  assign at    = MY_IDX == idx_i;

  always_comb begin
    value_nxt = value_r;
    if (ctl_i.ins) begin
      // open a gap: cells past the slot take their left neighbour
      if (at) begin
        value_nxt = load_value_i;
      end else if (!below) begin
        value_nxt = left_i;
      end
    end else if (ctl_i.del) begin
      if (!below) begin
        value_nxt = right_i;
      end
    end else if (ctl_i.rot_l) begin
      // idx is the tail, head value wraps round to it
      if (at) begin
        value_nxt = load_value_i;
      end else if (below) begin
        value_nxt = right_i;
      end
    end else if (ctl_i.rot_r) begin
      if (MY_IDX == '0) begin
        value_nxt = load_value_i;
      end else begin
        value_nxt = left_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

// File: sv/positional_sequence_store_core.sv
// Ordered store of up to CAPACITY signed 32-bit values held in a row of shifting cells.
// A request is taken when start is high and busy is low. Inserts and deletes finish in
// the cycle they are taken: the whole row shifts at once, and the single status result
// shows on out_valid in the next cycle. A read-out rotates the row one place per cycle and
// emits one entry per cycle, holding busy until it has produced the last entry; an empty
// store answers with one status result in the next cycle and never goes busy. The entry
// at the head of the row (the tail for a backward read) leaves each cycle and wraps round,
// so the row is back in order when the read ends.
// Results cannot be held off: out_valid marks each one for exactly one cycle.
module positional_sequence_store_core
  import pss_pkg::*;
#(
  parameter int CAPACITY = PSS_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic        [OP_W-1:0]  in_op,
  input  logic signed [VAL_W-1:0] in_new_value,
  input  logic        [POS_W-1:0] in_position,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic        [ST_W-1:0]  out_status,
  output logic                    out_last,
  output logic        [LEN_W-1:0] out_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                    state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic                    bwd_r, bwd_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [LEN_W-1:0]        out_length_r, out_length_nxt;

  pss_cell_ctl_t           ctl;
  logic [IDX_W-1:0]        idx;
  logic signed [VAL_W-1:0] load_value;
  logic signed [VAL_W-1:0] cell_q [CAPACITY];
  logic signed [VAL_W-1:0] tail_value;
  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        tail_idx;
  logic [EXT_W-1:0]        pos_e, cnt_e, pm1_e;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;

  assign busy     = (state_r == S_READ);
  assign accept   = start && !busy;
  assign cnt_m1   = count_r - CNT_W'(1);
  assign tail_idx = cnt_m1[IDX_W-1:0];
  assign tail_value = cell_q[tail_idx];
  assign pos_e    = EXT_W'(in_position);
  assign cnt_e    = EXT_W'(count_r);
  assign pm1_e    = pos_e - EXT_W'(1);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    rem_nxt            = rem_r;
    bwd_nxt            = bwd_r;
    ctl                = '0;
    idx                = '0;
    load_value         = in_new_value;
    out_valid_nxt      = 1'b0;
    out_read_value_nxt = '0;
    out_status_nxt     = STAT_OK;
    out_last_nxt       = 1'b1;
    out_length_nxt     = LEN_W'(count_r);

    if (state_r == S_IDLE) begin
      if (accept) begin
        out_valid_nxt = 1'b1;
        case (in_op)
          OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (is_full) begin
              out_status_nxt = STAT_FULL;
            end else if (in_op == OP_INS_POS &&
                         (pos_e == '0 || pos_e > cnt_e + EXT_W'(1))) begin
              out_status_nxt = STAT_RANGE;
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (in_op == OP_INS_FRONT) begin
                idx = '0;
              end else if (in_op == OP_INS_BACK) begin
                idx = count_r[IDX_W-1:0];
              end else begin
                idx = pm1_e[IDX_W-1:0];
              end
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            if (is_empty) begin
              out_status_nxt = STAT_EMPTY;
            end else if (in_op == OP_DEL_POS && (pos_e == '0 || pos_e > cnt_e)) begin
              out_status_nxt = STAT_RANGE;
            end else begin
              ctl.del   = 1'b1;
              count_nxt = cnt_m1;
              if (in_op == OP_DEL_FRONT) begin
                idx = '0;
              end else if (in_op == OP_DEL_BACK) begin
                idx = tail_idx;
              end else begin
                idx = pm1_e[IDX_W-1:0];
              end
            end
          end
          OP_READ_FWD, OP_READ_BWD: begin
            if (is_empty) begin
              out_status_nxt = STAT_EMPTY;
            end else begin
              // the block first moves to the read state; each entry is then registered onto the outputs
              out_valid_nxt = 1'b0;
              state_nxt     = S_READ;
              rem_nxt       = count_r;
              bwd_nxt       = (in_op == OP_READ_BWD);
            end
          end
          default: begin
            out_status_nxt = STAT_OK;
          end
        endcase
        out_length_nxt = LEN_W'(count_nxt);
      end
    end else begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (rem_r == CNT_W'(1));
      rem_nxt       = rem_r - CNT_W'(1);
      if (bwd_r) begin
        ctl.rot_r          = 1'b1;
        load_value         = tail_value;
        out_read_value_nxt = tail_value;
      end else begin
        ctl.rot_l          = 1'b1;
        idx                = tail_idx;
        load_value         = cell_q[0];
        out_read_value_nxt = cell_q[0];
      end
      if (rem_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_body
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_q[i+1];
    end
    pss_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .idx_i        (idx),
      .load_value_i (load_value),
      .left_i       (left_v),
      .right_i      (right_v),
      .value_o      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_read_value_r <= out_read_value_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
    out_length_r     <= out_length_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign out_length     = out_length_r;

endmodule

// File: sv/pss_checker.sv
module pss_checker
  import pss_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic        [OP_W-1:0]  in_op,
  input logic signed [VAL_W-1:0] in_new_value,
  input logic        [POS_W-1:0] in_position,
  input logic                    out_valid,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic        [ST_W-1:0]  out_status,
  input logic                    out_last,
  input logic        [LEN_W-1:0] out_length
);

  // a failed request is always a single marked result with no data
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_last && out_read_value == '0)
    else $error("status result not marked last or carries data");

  // read-out entries come back to back
  a_read_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a read-out");

  // while more entries are due the block takes no request
  a_busy_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("not busy during read-out");

  // nothing comes out without a request or a read in progress
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !out_valid)
    else $error("result without request");

  // length cannot change across the entries of one read-out
  a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> $stable(out_length))
    else $error("length moved during read-out");

endmodule

bind positional_sequence_store_core pss_checker u_pss_checker (.*);
